// ===== hdl/sidau_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; imported by sidau_dabble and the top level.
`timescale 1ns / 1ps

package sidau_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS  = 7;

   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 7'd45;

   // Shift-and-add-3 correction: a BCD digit of five or more gets three added
   // before the shift, so that it carries correctly into the next digit.
   localparam logic [DIGIT_BITS-1:0] DAB_LIMIT  = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DAB_ADJUST = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// Converts one signed integer per request into its decimal text, one ASCII
// character per response: an optional minus sign, then the digits most
// significant first with no leading zeros, the final character flagged by
// rsp_tlast. A request starts the bit-serial BCD converter; when the conversion
// is done the digits are captured, leading zero digits are removed one at a
// time, and then the characters are sent one per response, each held while the
// response side stalls. Every digit position is visited once, either stripped
// or sent. The request side is ready only while idle, so a new request is
// taken only after the previous one is converted, stripped and sent.
// Depends on sidau_pkg and sidau_dabble.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,  // [VALUE_BITS-1:0] value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [6:0] char_code
   output logic                              rsp_tlast
);
   import sidau_pkg::*;

   // Decimal digits of 2^(VALUE_BITS-1); 1233/4096 approximates log10(2).
   localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_BITS;
   localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  req_fire;
   logic                  conv_done;
   logic [BCD_W-1:0]      conv_bcd;

   logic [BCD_W-1:0]      digits_ff, digits_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DIGIT_BITS-1:0] top_digit;
   logic                  out_free;
   logic                  load_sign;
   logic                  load_digit;

   assign value     = req_tdata[VALUE_BITS-1:0];
   assign magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
   assign req_fire  = req_tvalid && req_tready;
   assign top_digit = digits_ff[BCD_W-1 -: DIGIT_BITS];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   sidau_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .magnitude (magnitude),
      .done      (conv_done),
      .bcd       (conv_bcd)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (conv_done) begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (top_digit != '0 || dcnt_ff == DCNT_W'(1)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && dcnt_ff == DCNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      load_sign   = (state_ff == ST_SIGN) && out_free;
      load_digit  = (state_ff == ST_EMIT) && out_free;
      digits_in   = digits_ff;
      dcnt_in     = dcnt_ff;
      neg_in      = neg_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;

      if (req_fire) begin
         neg_in = value[VALUE_BITS-1];
      end
      if (state_ff == ST_CONVERT && conv_done) begin
         digits_in = conv_bcd;
         dcnt_in   = DCNT_W'(NUM_DIGITS);
      end
      // Leading zeros are shifted out, but the units digit always stays.
      if (state_ff == ST_STRIP && top_digit == '0 && dcnt_ff != DCNT_W'(1)) begin
         digits_in = digits_ff << DIGIT_BITS;
         dcnt_in   = dcnt_ff - 1'b1;
      end
      if (load_sign) begin
         rsp_char_in = CH_MINUS;
         rsp_last_in = 1'b0;
      end
      if (load_digit) begin
         rsp_char_in = CH_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, top_digit};
         rsp_last_in = (dcnt_ff == DCNT_W'(1));
         digits_in   = digits_ff << DIGIT_BITS;
         dcnt_in     = dcnt_ff - 1'b1;
      end

      if (load_sign || load_digit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff   <= digits_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/sidau_dabble.sv =====
// Iterative binary to BCD converter (shift-and-add-3), one bit per cycle.
// Depends on sidau_pkg for the digit width and correction constants.
`timescale 1ns / 1ps

module sidau_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int NUM_DIGITS = 10
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [VALUE_BITS-1:0]                     magnitude,
   output logic                                      done,
   output logic [NUM_DIGITS*sidau_pkg::DIGIT_BITS-1:0] bcd
);
   import sidau_pkg::*;

   localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   // Every digit is corrected independently before the shared shift.
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_BITS +: DIGIT_BITS] >= DAB_LIMIT) begin
            bcd_adj[d*DIGIT_BITS +: DIGIT_BITS] =
               bcd_ff[d*DIGIT_BITS +: DIGIT_BITS] + DAB_ADJUST;
         end else begin
            bcd_adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[d*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = magnitude;
         bcd_in   = '0;
         cnt_in   = CNT_W'(VALUE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = {bcd_adj[BCD_W-2:0], shift_ff[VALUE_BITS-1]};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
